[rtl/fts_pkg.sv]
// Shared constants and types for the frame time statistics window unit.
package fts_pkg;

	localparam int TIME_BITS  = 24;
	localparam int SUM_BITS   = TIME_BITS + 1;
	localparam int RATE_BITS  = 20;
	localparam int RSUM_BITS  = 48;
	localparam int DVD_BITS   = RSUM_BITS;
	localparam int STEP_BITS  = $clog2(DVD_BITS + 1);
	localparam int FRAME_BITS = 32;

	localparam logic [RATE_BITS-1:0] RATE_MAX      = RATE_BITS'(1000000);
	localparam logic [TIME_BITS-1:0] WIN_LEN_RST   = TIME_BITS'(1000000);
	localparam logic [TIME_BITS-1:0] MIN_START_RST = TIME_BITS'(111000);

	localparam logic CFG_WIN_LEN   = 1'b0;
	localparam logic CFG_MIN_START = 1'b1;

	typedef struct packed {
		logic                 start;
		logic [DVD_BITS-1:0]  dividend;
		logic [TIME_BITS-1:0] divisor;
		logic [STEP_BITS-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DVD_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

[rtl/fts_div.sv]
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
module fts_div (
	input  logic             clk,
	input  logic             arst_n,
	input  fts_pkg::div_req_t req,
	output fts_pkg::div_rsp_t rsp
);
	import fts_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic [DVD_BITS-1:0]  dvd_q;
	logic [DVD_BITS-1:0]  quo_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] dsr_q;
	logic [TIME_BITS:0]   trial;
	logic                 ge;

	assign trial = {rem_q, dvd_q[DVD_BITS-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == STEP_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_BITS'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_BITS-2:0], 1'b0};
			quo_q <= {quo_q[DVD_BITS-2:0], ge};
			rem_q <= ge ? TIME_BITS'(trial - {1'b0, dsr_q}) : trial[TIME_BITS-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/frame_time_stats_window_unit.sv]
// Top level: window statistics sequencer around the shared divider.
//
//   channel | signals                             | beat carries
//   cfg     | cfg_valid, cfg_ready                | cfg_index, cfg_data
//   in      | in_valid, in_ready                  | frame_time
//   out     | out_valid, out_ready                | published statistics, frame_index
//
// A frame's time from one input beat to the next is set by the bit-serial divider, which runs
// the rate division (20 steps, skipped at zero duration) and, when the frame closes a window,
// the average time (25) and average rate (48) divisions.
// Reset loads the register defaults and clears the window; no clearing pass.
// in_ready is high only while the sequencer is idle; a result waiting on the output
// register does not block acceptance of the next frame, only the commit of that frame.
// cfg_ready is always high.
module frame_time_stats_window_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [fts_pkg::TIME_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [fts_pkg::TIME_BITS-1:0]       frame_time,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fts_pkg::TIME_BITS-1:0]       last_frame_time,
	output logic [fts_pkg::TIME_BITS-1:0]       min_frame_time,
	output logic [fts_pkg::TIME_BITS-1:0]       max_frame_time,
	output logic [fts_pkg::RATE_BITS-1:0]       frame_rate,
	output logic [fts_pkg::TIME_BITS-1:0]       avg_frame_time,
	output logic [fts_pkg::RATE_BITS-1:0]       avg_frame_rate,
	output logic [fts_pkg::FRAME_BITS-1:0]      publish_frame_index,
	output logic [fts_pkg::FRAME_BITS-1:0]      frame_index,
	output logic                                published
);
	import fts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RATE,
		S_ACC,
		S_AVG_T,
		S_AVG_R,
		S_COMMIT
	} state_t;

	state_t state_q;

	logic [TIME_BITS-1:0]  win_len_q;
	logic [TIME_BITS-1:0]  min_start_q;

	logic [TIME_BITS-1:0]  dur_q;
	logic [RATE_BITS-1:0]  rate_q;
	logic                  pub_q;
	logic [SUM_BITS-1:0]   win_sum_q;
	logic [TIME_BITS-1:0]  win_min_q;
	logic [TIME_BITS-1:0]  win_max_q;
	logic [RSUM_BITS-1:0]  rate_sum_q;
	logic [TIME_BITS-1:0]  win_cnt_q;
	logic [FRAME_BITS-1:0] frame_cnt_q;
	logic [TIME_BITS-1:0]  avg_t_q;
	logic [RATE_BITS-1:0]  avg_r_q;

	logic                  out_valid_q;
	logic                  published_q;
	logic [FRAME_BITS-1:0] frame_index_q;
	logic [TIME_BITS-1:0]  shown_last_q;
	logic [TIME_BITS-1:0]  shown_min_q;
	logic [TIME_BITS-1:0]  shown_max_q;
	logic [RATE_BITS-1:0]  shown_rate_q;
	logic [TIME_BITS-1:0]  shown_avg_t_q;
	logic [RATE_BITS-1:0]  shown_avg_r_q;
	logic [FRAME_BITS-1:0] shown_frame_q;

	logic [SUM_BITS:0]     sum_wide;
	logic [SUM_BITS-1:0]   sum_n;
	logic [RSUM_BITS:0]    rsum_wide;
	logic [RSUM_BITS-1:0]  rsum_n;
	logic [TIME_BITS-1:0]  cnt_n;
	logic [TIME_BITS-1:0]  min_n;
	logic [TIME_BITS-1:0]  max_n;
	logic                  pub_n;
	logic                  commit_ok;

	div_req_t div_req;
	div_rsp_t div_rsp;

	fts_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign sum_wide  = {1'b0, win_sum_q} + {(SUM_BITS + 1 - TIME_BITS)'(0), dur_q};
	assign sum_n     = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
	assign rsum_wide = {1'b0, rate_sum_q} + {(RSUM_BITS + 1 - RATE_BITS)'(0), rate_q};
	assign rsum_n    = rsum_wide[RSUM_BITS] ? '1 : rsum_wide[RSUM_BITS-1:0];
	assign cnt_n     = (win_cnt_q == '1) ? win_cnt_q : win_cnt_q + 1'b1;
	assign min_n     = (dur_q < win_min_q) ? dur_q : win_min_q;
	assign max_n     = (dur_q > win_max_q) ? dur_q : win_max_q;
	assign pub_n     = sum_n > {1'b0, win_len_q};
	assign commit_ok = !out_valid_q || out_ready;

	always_comb begin
		div_req = '0;
		case (state_q)
			S_IDLE: begin
				div_req.start    = in_valid && (frame_time != '0);
				div_req.dividend = {RATE_MAX, (DVD_BITS - RATE_BITS)'(0)};
				div_req.divisor  = frame_time;
				div_req.steps    = STEP_BITS'(RATE_BITS);
			end
			S_ACC: begin
				div_req.start    = pub_n;
				div_req.dividend = {sum_n, (DVD_BITS - SUM_BITS)'(0)};
				div_req.divisor  = cnt_n;
				div_req.steps    = STEP_BITS'(SUM_BITS);
			end
			S_AVG_T: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = rate_sum_q;
				div_req.divisor  = win_cnt_q;
				div_req.steps    = STEP_BITS'(RSUM_BITS);
			end
			default: div_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WIN_LEN_RST;
			min_start_q <= MIN_START_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIN_LEN:   win_len_q   <= cfg_data;
				CFG_MIN_START: min_start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			dur_q         <= '0;
			rate_q        <= '0;
			pub_q         <= 1'b0;
			avg_t_q       <= '0;
			avg_r_q       <= '0;
			win_sum_q     <= '0;
			win_min_q     <= MIN_START_RST;
			win_max_q     <= '0;
			rate_sum_q    <= '0;
			win_cnt_q     <= '0;
			frame_cnt_q   <= '0;
			out_valid_q   <= 1'b0;
			published_q   <= 1'b0;
			frame_index_q <= '0;
			shown_last_q  <= '0;
			shown_min_q   <= MIN_START_RST;
			shown_max_q   <= '0;
			shown_rate_q  <= '0;
			shown_avg_t_q <= '0;
			shown_avg_r_q <= '0;
			shown_frame_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_COMMIT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dur_q <= frame_time;
						if (frame_time == '0) begin
							rate_q  <= RATE_MAX;
							state_q <= S_ACC;
						end else begin
							state_q <= S_RATE;
						end
					end
				end
				S_RATE: begin
					if (div_rsp.done) begin
						rate_q  <= div_rsp.quotient[RATE_BITS-1:0];
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					win_sum_q  <= sum_n;
					win_min_q  <= min_n;
					win_max_q  <= max_n;
					rate_sum_q <= rsum_n;
					win_cnt_q  <= cnt_n;
					pub_q      <= pub_n;
					state_q    <= pub_n ? S_AVG_T : S_COMMIT;
				end
				S_AVG_T: begin
					if (div_rsp.done) begin
						avg_t_q <= (div_rsp.quotient[SUM_BITS-1:TIME_BITS] != '0) ? '1 :
							div_rsp.quotient[TIME_BITS-1:0];
						state_q <= S_AVG_R;
					end
				end
				S_AVG_R: begin
					if (div_rsp.done) begin
						avg_r_q <= (div_rsp.quotient > {(DVD_BITS - RATE_BITS)'(0), RATE_MAX}) ?
							RATE_MAX : div_rsp.quotient[RATE_BITS-1:0];
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (commit_ok) begin
						out_valid_q   <= 1'b1;
						published_q   <= pub_q;
						frame_index_q <= frame_cnt_q;
						frame_cnt_q   <= frame_cnt_q + 1'b1;
						if (pub_q) begin
							shown_last_q  <= dur_q;
							shown_min_q   <= win_min_q;
							shown_max_q   <= win_max_q;
							shown_rate_q  <= rate_q;
							shown_avg_t_q <= avg_t_q;
							shown_avg_r_q <= avg_r_q;
							shown_frame_q <= frame_cnt_q;
							win_sum_q     <= '0;
							win_min_q     <= min_start_q;
							win_max_q     <= '0;
							rate_sum_q    <= '0;
							win_cnt_q     <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready           = 1'b1;
	assign in_ready            = (state_q == S_IDLE);
	assign out_valid           = out_valid_q;
	assign last_frame_time     = shown_last_q;
	assign min_frame_time      = shown_min_q;
	assign max_frame_time      = shown_max_q;
	assign frame_rate          = shown_rate_q;
	assign avg_frame_time      = shown_avg_t_q;
	assign avg_frame_rate      = shown_avg_r_q;
	assign publish_frame_index = shown_frame_q;
	assign frame_index         = frame_index_q;
	assign published           = published_q;

endmodule
